FILE: rtl/mmac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmac_pkg
// shared constants, codes and state types of the matrix multiply-accumulate
// ----------------------------------------------------------------------------
package mmac_pkg;

  localparam int MAX_N_DEF = 64;
  localparam logic [6:0] SIZE_RESET = 7'd64;

  // item codes
  localparam logic [2:0] FN_WR_A = 3'd0;
  localparam logic [2:0] FN_WR_B = 3'd1;
  localparam logic [2:0] FN_WR_C = 3'd2;
  localparam logic [2:0] FN_RUN  = 3'd3;
  localparam logic [2:0] FN_RD_C = 3'd4;

  // binary64 default nan
  localparam logic [63:0] FP_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_HOLD,
    ST_CADR,
    ST_CLD,
    ST_ABADR,
    ST_START,
    ST_WAIT,
    ST_WRC
  } seq_state_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_MUL,
    FS_NORM,
    FS_RND,
    FS_ADDSET,
    FS_ALIGN,
    FS_ADD
  } fpu_state_t;

endpackage
`default_nettype wire

FILE: rtl/mmac_intf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmac channel interfaces
// item, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface mmac_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [5:0]  row;
  logic [5:0]  col;
  logic [63:0] value;
  modport source (output valid, func, row, col, value, input ready);
  modport sink (input valid, func, row, col, value, output ready);
endinterface

interface mmac_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_value;
  logic        status;
  modport source (output valid, read_value, status, input ready);
  modport sink (input valid, read_value, status, output ready);
endinterface

interface mmac_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] matrix_size;
  modport source (output valid, matrix_size, input ready);
  modport sink (input valid, matrix_size, output ready);
endinterface
`default_nettype wire

FILE: rtl/mmac_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmac_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mmac_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/mmac_fpu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmac_fpu
// iterative binary64 unit: c + a*b with the product and the sum each rounded
// to nearest-even, sharing one normalize and round path
// ----------------------------------------------------------------------------
module mmac_fpu (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  input  wire logic [63:0] c,
  output logic             done,
  output logic [63:0]      result
);

  localparam int MW = 108;
  localparam int EW = 14;
  localparam logic signed [EW-1:0] E_ONE     = 14'sd1;
  localparam logic signed [EW-1:0] E_MAX     = 14'sd2047;
  localparam logic signed [EW-1:0] E_MULBIAS = 14'sd1022;
  localparam logic signed [EW-1:0] E_STEP    = 14'sd8;
  localparam logic signed [EW-1:0] E_FAR     = 14'sd110;

  mmac_pkg::fpu_state_t state, state_next;

  logic [52:0]            ma, mb;
  logic [63:0]            opc, prod;
  logic [MW-1:0]          rm, bigm;
  logic signed [EW-1:0]   re, te;
  logic                   rs, sub, phase_add;
  logic [2:0]             pcnt;
  logic [53:0]            pp;

  logic                   fin;
  logic [63:0]            fin_val;

  function automatic logic is_nan(input logic [63:0] x);
    is_nan = (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  function automatic logic is_inf(input logic [63:0] x);
    is_inf = (x[62:52] == 11'h7FF) && (x[51:0] == 52'd0);
  endfunction

  function automatic logic is_zero(input logic [63:0] x);
    is_zero = (x[62:0] == 63'd0);
  endfunction

  function automatic logic [52:0] mant(input logic [63:0] x);
    mant = {x[62:52] != 11'd0, x[51:0]};
  endfunction

  function automatic logic signed [EW-1:0] expo(input logic [63:0] x);
    expo = (x[62:52] == 11'd0) ? E_ONE : $signed({3'b000, x[62:52]});
  endfunction

  function automatic logic [MW-1:0] rsh_jam(input logic [MW-1:0] m, input logic [3:0] s);
    logic [MW-1:0] lost;
    lost = m & ~({MW{1'b1}} << s);
    rsh_jam = (m >> s) | {{(MW-1){1'b0}}, |lost};
  endfunction

  function automatic logic [63:0] fp_round(input logic s, input logic signed [EW-1:0] e,
                                           input logic [MW-1:0] m);
    logic [52:0]          mt;
    logic                 g, st, up;
    logic [53:0]          sum;
    logic [52:0]          mr;
    logic signed [EW-1:0] e2;
    mt  = m[MW-1 -: 53];
    g   = m[MW-54];
    st  = |m[MW-55:0];
    up  = g & (st | mt[0]);
    sum = {1'b0, mt} + {53'd0, up};
    if (sum[53]) begin
      mr = sum[53:1];
      e2 = e + E_ONE;
    end else begin
      mr = sum[52:0];
      e2 = e;
    end
    if (e2 >= E_MAX) begin
      fp_round = {s, 11'h7FF, 52'd0};
    end else begin
      fp_round = {s, mr[52] ? e2[10:0] : 11'd0, mr[51:0]};
    end
  endfunction

  // product special cases
  logic        ms_hit;
  logic [63:0] ms_val;
  always_comb begin
    ms_hit = 1'b1;
    ms_val = 64'd0;
    if (is_nan(a)) begin
      ms_val = a | 64'h0008_0000_0000_0000;
    end else if (is_nan(b)) begin
      ms_val = b | 64'h0008_0000_0000_0000;
    end else if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) begin
      ms_val = mmac_pkg::FP_DEFAULT_NAN;
    end else if (is_inf(a) || is_inf(b)) begin
      ms_val = {a[63] ^ b[63], 11'h7FF, 52'd0};
    end else if (is_zero(a) || is_zero(b)) begin
      ms_val = {a[63] ^ b[63], 63'd0};
    end else begin
      ms_hit = 1'b0;
    end
  end

  // sum special cases
  logic        as_hit, cancel, c_big;
  logic [63:0] as_val, big, small_op;
  always_comb begin
    as_hit = 1'b1;
    as_val = 64'd0;
    if (is_nan(opc)) begin
      as_val = opc | 64'h0008_0000_0000_0000;
    end else if (is_nan(prod)) begin
      as_val = prod | 64'h0008_0000_0000_0000;
    end else if (is_inf(opc) && is_inf(prod) && (opc[63] != prod[63])) begin
      as_val = mmac_pkg::FP_DEFAULT_NAN;
    end else if (is_inf(opc)) begin
      as_val = opc;
    end else if (is_inf(prod)) begin
      as_val = prod;
    end else if (is_zero(opc) && is_zero(prod)) begin
      as_val = {opc[63] & prod[63], 63'd0};
    end else if (is_zero(opc)) begin
      as_val = prod;
    end else if (is_zero(prod)) begin
      as_val = opc;
    end else begin
      as_hit = 1'b0;
    end
    cancel   = (opc[62:0] == prod[62:0]) && (opc[63] != prod[63]);
    c_big    = (opc[62:0] >= prod[62:0]);
    big      = c_big ? opc : prod;
    small_op = c_big ? prod : opc;
  end

  // shift step amounts
  logic signed [EW-1:0] rdist, adist, lsh_lim;
  logic [3:0]           rsh_s, ash_s, lz8, lsh_s;
  always_comb begin
    rdist = E_ONE - re;
    adist = te - re;
    rsh_s = (rdist > E_STEP) ? 4'd8 : rdist[3:0];
    ash_s = (adist > E_STEP) ? 4'd8 : adist[3:0];
    lz8   = 4'd8;
    for (int p = 0; p < 8; p++) begin
      if (rm[MW-8+p]) begin
        lz8 = 4'(7 - p);
      end
    end
    lsh_lim = re - E_ONE;
    lsh_s   = ($signed({{(EW-4){1'b0}}, lz8}) < lsh_lim) ? lz8 : lsh_lim[3:0];
  end

  // partial product operands and placement
  logic [26:0] px, py;
  logic [6:0]  psh;
  always_comb begin
    px = pcnt[0] ? {1'b0, ma[52:27]} : ma[26:0];
    py = pcnt[1] ? {1'b0, mb[52:27]} : mb[26:0];
    case (pcnt)
      3'd1:    psh = 7'd2;
      3'd2:    psh = 7'd29;
      3'd3:    psh = 7'd29;
      default: psh = 7'd56;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mmac_pkg::FS_IDLE: begin
        if (start) begin
          state_next = ms_hit ? mmac_pkg::FS_ADDSET : mmac_pkg::FS_MUL;
        end
      end
      mmac_pkg::FS_MUL: begin
        if (pcnt == 3'd4) begin
          state_next = mmac_pkg::FS_NORM;
        end
      end
      mmac_pkg::FS_NORM: begin
        if (!(re < E_ONE) && !(!rm[MW-1] && re > E_ONE)) begin
          state_next = mmac_pkg::FS_RND;
        end
      end
      mmac_pkg::FS_RND: begin
        state_next = phase_add ? mmac_pkg::FS_IDLE : mmac_pkg::FS_ADDSET;
      end
      mmac_pkg::FS_ADDSET: begin
        state_next = fin ? mmac_pkg::FS_IDLE : mmac_pkg::FS_ALIGN;
      end
      mmac_pkg::FS_ALIGN: begin
        if (adist == '0 || adist > E_FAR) begin
          state_next = mmac_pkg::FS_ADD;
        end
      end
      mmac_pkg::FS_ADD: begin
        state_next = mmac_pkg::FS_NORM;
      end
      default: state_next = mmac_pkg::FS_IDLE;
    endcase
  end

  // finish
  always_comb begin
    fin     = 1'b0;
    fin_val = 64'd0;
    unique case (state)
      mmac_pkg::FS_ADDSET: begin
        if (as_hit) begin
          fin     = 1'b1;
          fin_val = as_val;
        end else if (cancel) begin
          fin     = 1'b1;
          fin_val = 64'd0;
        end
      end
      mmac_pkg::FS_RND: begin
        if (phase_add) begin
          fin     = 1'b1;
          fin_val = fp_round(rs, re, rm);
        end
      end
      default: fin = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmac_pkg::FS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      result <= fin_val;
    end
    unique case (state)
      mmac_pkg::FS_IDLE: begin
        if (start) begin
          opc       <= c;
          prod      <= ms_val;
          ma        <= mant(a);
          mb        <= mant(b);
          rs        <= a[63] ^ b[63];
          re        <= expo(a) + expo(b) - E_MULBIAS;
          rm        <= '0;
          pcnt      <= 3'd0;
          phase_add <= 1'b0;
        end
      end
      mmac_pkg::FS_MUL: begin
        pp   <= px * py;
        pcnt <= pcnt + 3'd1;
        if (pcnt != 3'd0) begin
          rm <= rm + (MW'(pp) << psh);
        end
      end
      mmac_pkg::FS_NORM: begin
        if (re < E_ONE) begin
          if (rdist > E_FAR) begin
            rm <= {{(MW-1){1'b0}}, |rm};
            re <= E_ONE;
          end else begin
            rm <= rsh_jam(rm, rsh_s);
            re <= re + $signed({{(EW-4){1'b0}}, rsh_s});
          end
        end else if (!rm[MW-1] && re > E_ONE) begin
          rm <= rm << lsh_s;
          re <= re - $signed({{(EW-4){1'b0}}, lsh_s});
        end
      end
      mmac_pkg::FS_RND: begin
        if (!phase_add) begin
          prod <= fp_round(rs, re, rm);
        end
      end
      mmac_pkg::FS_ADDSET: begin
        rm        <= {1'b0, mant(small_op), 54'd0};
        re        <= expo(small_op) + E_ONE;
        te        <= expo(big) + E_ONE;
        bigm      <= {1'b0, mant(big), 54'd0};
        rs        <= big[63];
        sub       <= opc[63] ^ prod[63];
        phase_add <= 1'b1;
      end
      mmac_pkg::FS_ALIGN: begin
        if (adist > E_FAR) begin
          rm <= {{(MW-1){1'b0}}, |rm};
          re <= te;
        end else if (adist != '0) begin
          rm <= rsh_jam(rm, ash_s);
          re <= re + $signed({{(EW-4){1'b0}}, ash_s});
        end
      end
      mmac_pkg::FS_ADD: begin
        rm <= sub ? (bigm - rm) : (bigm + rm);
        re <= te;
      end
      default: rm <= rm;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/matrix_multiply_accumulate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate
// square binary64 c += a*b over three element stores with one shared fp unit
// ----------------------------------------------------------------------------
//  channel   dir  payload                     beat
//  cfg       in   matrix_size                 register write
//  items     in   func, row, col, value       one command
//  results   out  read_value, status          one per command
//
//  writes, flagged items, unused codes and an empty pass finish in the idle state
//  and a read goes through the read state; a compute pass loads each c element,
//  runs the fp unit once per term and writes the element back; the fp unit
//  shifts at most 8 bits per step and skips the multiply on special products
//  items is held low while a command is at work and while a finished beat waits
//  behind a full results register; reset is synchronous and active high
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate #(
  parameter int MAX_N = mmac_pkg::MAX_N_DEF
) (
  input wire logic    clk,
  input wire logic    rst,
  mmac_cfg_if.sink    cfg,
  mmac_in_if.sink     items,
  mmac_out_if.source  results
);

  localparam int IW    = $clog2(MAX_N);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;
  localparam int NW    = $clog2(MAX_N + 1);
  localparam int CW    = (NW > 6) ? NW : 6;
  localparam int SW    = (NW > 7) ? NW : 7;

  mmac_pkg::seq_state_t state, state_next;

  logic [6:0]    msize;
  logic [NW-1:0] n;
  logic [IW-1:0] i, j, k;
  logic [63:0]   acc;
  logic [63:0]   res_value;
  logic          res_status;

  logic          accept, free, oor;
  logic          last_i, last_j, last_k;
  logic          fin, fin_status;
  logic [63:0]   fin_value;

  logic          a_we, b_we, c_we, fpu_start, fpu_done;
  logic [AW-1:0] wr_addr, c_waddr, c_raddr;
  logic [63:0]   c_wdata, a_rdata, b_rdata, c_rdata, fpu_result;

  assign n = (SW'(msize) > SW'(MAX_N)) ? NW'(MAX_N) : NW'(msize);

  assign items.ready = (state == mmac_pkg::ST_IDLE);
  assign cfg.ready   = 1'b1;
  assign accept      = items.valid && items.ready;
  assign free        = !results.valid || results.ready;
  assign oor         = (CW'(items.row) >= CW'(n)) || (CW'(items.col) >= CW'(n));
  assign wr_addr     = {IW'(items.row), IW'(items.col)};
  assign last_i      = (NW'(i) + NW'(1)) == n;
  assign last_j      = (NW'(j) + NW'(1)) == n;
  assign last_k      = (NW'(k) + NW'(1)) == n;

  mmac_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_a_ram (
    .clk(clk), .we(a_we), .waddr(wr_addr), .wdata(items.value),
    .raddr({i, k}), .rdata(a_rdata)
  );

  mmac_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_b_ram (
    .clk(clk), .we(b_we), .waddr(wr_addr), .wdata(items.value),
    .raddr({k, j}), .rdata(b_rdata)
  );

  mmac_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_c_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  mmac_fpu u_fpu (
    .clk(clk), .rst(rst), .start(fpu_start),
    .a(a_rdata), .b(b_rdata), .c(acc),
    .done(fpu_done), .result(fpu_result)
  );

  // outputs
  always_comb begin
    a_we       = 1'b0;
    b_we       = 1'b0;
    c_we       = 1'b0;
    c_waddr    = wr_addr;
    c_wdata    = items.value;
    c_raddr    = {i, j};
    fpu_start  = 1'b0;
    fin        = 1'b0;
    fin_value  = 64'd0;
    fin_status = 1'b0;
    unique case (state)
      mmac_pkg::ST_IDLE: begin
        c_raddr = wr_addr;
        if (accept) begin
          unique case (items.func) inside
            mmac_pkg::FN_WR_A, mmac_pkg::FN_WR_B, mmac_pkg::FN_WR_C: begin
              a_we       = !oor && (items.func == mmac_pkg::FN_WR_A);
              b_we       = !oor && (items.func == mmac_pkg::FN_WR_B);
              c_we       = !oor && (items.func == mmac_pkg::FN_WR_C);
              fin        = 1'b1;
              fin_status = oor;
            end
            mmac_pkg::FN_RD_C: begin
              fin        = oor;
              fin_status = oor;
            end
            mmac_pkg::FN_RUN: begin
              fin = (n == '0);
            end
            default: fin = 1'b1;
          endcase
        end
      end
      mmac_pkg::ST_READ: begin
        fin       = 1'b1;
        fin_value = c_rdata;
      end
      mmac_pkg::ST_START: begin
        fpu_start = 1'b1;
      end
      mmac_pkg::ST_WRC: begin
        c_we    = 1'b1;
        c_waddr = {i, j};
        c_wdata = acc;
        fin     = last_i && last_j;
      end
      default: fin = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mmac_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (items.func == mmac_pkg::FN_RD_C) ? mmac_pkg::ST_READ
                                                         : mmac_pkg::ST_CADR;
        end
      end
      mmac_pkg::ST_READ:  state_next = mmac_pkg::ST_IDLE;
      mmac_pkg::ST_HOLD: begin
        if (free) begin
          state_next = mmac_pkg::ST_IDLE;
        end
      end
      mmac_pkg::ST_CADR:  state_next = mmac_pkg::ST_CLD;
      mmac_pkg::ST_CLD:   state_next = mmac_pkg::ST_ABADR;
      mmac_pkg::ST_ABADR: state_next = mmac_pkg::ST_START;
      mmac_pkg::ST_START: state_next = mmac_pkg::ST_WAIT;
      mmac_pkg::ST_WAIT: begin
        if (fpu_done) begin
          state_next = last_k ? mmac_pkg::ST_WRC : mmac_pkg::ST_ABADR;
        end
      end
      mmac_pkg::ST_WRC:   state_next = mmac_pkg::ST_CADR;
      default:            state_next = mmac_pkg::ST_IDLE;
    endcase
    if (fin) begin
      state_next = free ? mmac_pkg::ST_IDLE : mmac_pkg::ST_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mmac_pkg::ST_IDLE;
      msize         <= mmac_pkg::SIZE_RESET;
      results.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        msize <= cfg.matrix_size;
      end
      if (fin && free) begin
        results.valid      <= 1'b1;
        results.read_value <= fin_value;
        results.status     <= fin_status;
      end else if (state == mmac_pkg::ST_HOLD && free) begin
        results.valid      <= 1'b1;
        results.read_value <= res_value;
        results.status     <= res_status;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin && !free) begin
      res_value  <= fin_value;
      res_status <= fin_status;
    end
    unique case (state)
      mmac_pkg::ST_IDLE: begin
        if (accept) begin
          i <= '0;
          j <= '0;
        end
      end
      mmac_pkg::ST_CLD: begin
        acc <= c_rdata;
        k   <= '0;
      end
      mmac_pkg::ST_WAIT: begin
        if (fpu_done) begin
          acc <= fpu_result;
          if (!last_k) begin
            k <= k + IW'(1);
          end
        end
      end
      mmac_pkg::ST_WRC: begin
        if (last_j) begin
          j <= '0;
          i <= i + IW'(1);
        end else begin
          j <= j + IW'(1);
        end
      end
      default: acc <= acc;
    endcase
  end

endmodule
`default_nettype wire

FILE: dv/mmac_result_checker.sv
// ----------------------------------------------------------------------------
// mmac_result_checker
// watches the config, item and result channels of the matrix multiply-
// accumulate, keeps its own copy of the three element stores and the size
// register, predicts the result beat of every accepted item and compares
// each result beat in order, counting every mismatch
// ----------------------------------------------------------------------------
module mmac_result_checker #(
  parameter int MAX_N = mmac_pkg::MAX_N_DEF
) (
  input  logic clk,
  input  logic rst,
  mmac_cfg_if  cfg,
  mmac_in_if   items,
  mmac_out_if  results,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [63:0] read_value;
    logic        status;
  } mmac_result_t;

  mmac_result_t expected_results[$];
  logic [63:0]  a_mem[MAX_N*MAX_N];
  logic [63:0]  b_mem[MAX_N*MAX_N];
  logic [63:0]  c_mem[MAX_N*MAX_N];
  logic [6:0]   size_q;

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch on %s: got %h expected %h", field, got, want);
    fail_count++;
  endtask

  function automatic bit is_nan(input logic [63:0] x);
    return (x[62:52] == 11'h7ff) && (x[51:0] != 52'd0);
  endfunction

  // any nan stands for an expected nan, payloads are not compared
  function automatic bit fp_same(input logic [63:0] got, input logic [63:0] want);
    if (is_nan(want)) return is_nan(got);
    return got == want;
  endfunction

  // c += a*b with product and sum rounded separately, k ascending
  task automatic accumulate_product(input int n);
    real acc;
    real prod;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = $bitstoreal(c_mem[i*MAX_N+j]);
        for (int k = 0; k < n; k++) begin
          prod = $bitstoreal(a_mem[i*MAX_N+k]) * $bitstoreal(b_mem[k*MAX_N+j]);
          acc = acc + prod;
        end
        c_mem[i*MAX_N+j] = $realtobits(acc);
      end
    end
  endtask

  always @(posedge clk) begin
    mmac_result_t want;
    mmac_result_t got;
    int n;
    int idx;
    if (rst) begin
      size_q = mmac_pkg::SIZE_RESET;
      expected_results.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (results.valid && results.ready) begin
        got.read_value = results.read_value;
        got.status = results.status;
        if (expected_results.size() == 0) begin
          report("unexpected result beat", got.read_value, 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (!fp_same(got.read_value, want.read_value))
            report("read_value", got.read_value, want.read_value);
          if (got.status !== want.status)
            report("status", {63'd0, got.status}, {63'd0, want.status});
        end
      end
      if (cfg.valid && cfg.ready)
        size_q = cfg.matrix_size;
      if (items.valid && items.ready) begin
        n = (size_q > MAX_N) ? MAX_N : size_q;
        want = '0;
        case (items.func)
          mmac_pkg::FN_WR_A, mmac_pkg::FN_WR_B, mmac_pkg::FN_WR_C,
          mmac_pkg::FN_RD_C: begin
            if (items.row >= n || items.col >= n) begin
              want.status = 1'b1;
            end else begin
              idx = items.row * MAX_N + items.col;
              case (items.func)
                mmac_pkg::FN_WR_A: a_mem[idx] = items.value;
                mmac_pkg::FN_WR_B: b_mem[idx] = items.value;
                mmac_pkg::FN_WR_C: c_mem[idx] = items.value;
                default: want.read_value = c_mem[idx];
              endcase
            end
          end
          mmac_pkg::FN_RUN: accumulate_product(n);
          default: ;
        endcase
        expected_results.push_back(want);
      end
      pending = expected_results.size();
    end
  end

endmodule

FILE: dv/tb_matrix_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// tb_matrix_multiply_accumulate
// drives element loads, compute passes and read-backs into the matrix
// multiply-accumulate over several matrix sizes with random gaps on both
// channels and one long result stall; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_matrix_multiply_accumulate;

  localparam int MAX_N = 64;
  localparam int CYCLE_LIMIT = 5000000;

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  int   cycles = 0;
  int   n_cur;
  int   result_beats = 0;
  int   stall_left = 0;
  bit   long_stall_done = 1'b0;
  bit   no_gaps;
  bit   a_set[MAX_N*MAX_N];
  bit   b_set[MAX_N*MAX_N];
  bit   c_set[MAX_N*MAX_N];

  mmac_cfg_if cfg_ch();
  mmac_in_if  item_ch();
  mmac_out_if res_ch();

  matrix_multiply_accumulate #(.MAX_N(MAX_N)) uut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .items   (item_ch),
    .results (res_ch)
  );

  mmac_result_checker #(.MAX_N(MAX_N)) chk (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .items      (item_ch),
    .results    (res_ch),
    .fail_count (fails),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_matrix_multiply_accumulate failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && res_ch.valid && res_ch.ready) result_beats++;

  // result side: random gaps plus one long hold-off once traffic is flowing
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready = 1'b0;
    end else if (stall_left > 0) begin
      res_ch.ready = 1'b0;
      stall_left--;
    end else if (!long_stall_done && result_beats >= 40) begin
      long_stall_done = 1'b1;
      stall_left = 400;
      res_ch.ready = 1'b0;
    end else if (!no_gaps && $urandom_range(0, 99) < 3) begin
      stall_left = $urandom_range(5, 30);
      res_ch.ready = 1'b0;
    end else begin
      res_ch.ready = no_gaps ? 1'b1 : ($urandom_range(0, 99) < 75);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // finite operand of moderate magnitude
  function automatic logic [63:0] rnd_fp();
    logic [63:0] v;
    v = rnd64();
    v[62:52] = 11'($urandom_range(1003, 1043));
    return v;
  endfunction

  task automatic send(input logic [2:0] f, input int r, input int c, input logic [63:0] v);
    int gap;
    int idx;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid = 1'b1;
    item_ch.func = f;
    item_ch.row = 6'(r);
    item_ch.col = 6'(c);
    item_ch.value = v;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    if (r < n_cur && c < n_cur) begin
      idx = r * MAX_N + c;
      if (f == mmac_pkg::FN_WR_A) a_set[idx] = 1'b1;
      if (f == mmac_pkg::FN_WR_B) b_set[idx] = 1'b1;
      if (f == mmac_pkg::FN_WR_C) c_set[idx] = 1'b1;
    end
  endtask

  task automatic set_size(input int s);
    item_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.matrix_size = 7'(s);
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    n_cur = (s > MAX_N) ? MAX_N : s;
  endtask

  task automatic fill_all(input int n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        send(mmac_pkg::FN_WR_A, i, j, rnd_fp());
        send(mmac_pkg::FN_WR_B, i, j, rnd_fp());
        send(mmac_pkg::FN_WR_C, i, j, rnd_fp());
      end
  endtask

  // random mix; runs need every element in use loaded, left to the caller
  task automatic mix(input int count, input int max_runs);
    int r;
    int row;
    int col;
    int runs;
    logic [63:0] v;
    runs = 0;
    repeat (count) begin
      r = $urandom_range(0, 99);
      row = $urandom_range(0, n_cur - 1);
      col = $urandom_range(0, n_cur - 1);
      v = ($urandom_range(0, 99) < 5) ? rnd64() : rnd_fp();
      if (r < 20) begin
        send(3'($urandom_range(0, 2)), row, col, v);
      end else if (r < 30 && n_cur < MAX_N) begin
        if ($urandom_range(0, 1)) row = $urandom_range(n_cur, MAX_N - 1);
        else col = $urandom_range(n_cur, MAX_N - 1);
        send(3'($urandom_range(0, 2)), row, col, rnd64());
      end else if (r < 65) begin
        if (c_set[row*MAX_N+col]) send(mmac_pkg::FN_RD_C, row, col, rnd64());
        else send(mmac_pkg::FN_WR_C, row, col, v);
      end else if (r < 72 && n_cur < MAX_N) begin
        send(mmac_pkg::FN_RD_C, $urandom_range(n_cur, MAX_N - 1),
             $urandom_range(0, MAX_N - 1), rnd64());
      end else if (r < 76) begin
        send(3'($urandom_range(5, 7)), $urandom_range(0, 63), $urandom_range(0, 63),
             rnd64());
      end else if (r < 82 && runs < max_runs) begin
        send(mmac_pkg::FN_RUN, $urandom_range(0, 63), $urandom_range(0, 63), rnd64());
        runs++;
      end else begin
        send(mmac_pkg::FN_WR_C, row, col, v);
      end
    end
  endtask

  initial begin
    int sz;
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.matrix_size = '0;
    item_ch.valid = 1'b0;
    item_ch.func = '0;
    item_ch.row = '0;
    item_ch.col = '0;
    item_ch.value = '0;
    no_gaps = 1'b0;
    n_cur = MAX_N;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send(mmac_pkg::FN_WR_C, 0, 0, 64'h0000_0000_0000_0000);
    send(mmac_pkg::FN_WR_C, 63, 63, 64'hFFFF_FFFF_FFFF_FFFF);
    send(mmac_pkg::FN_WR_C, 0, 63, 64'h7FF0_0000_0000_0000);
    send(mmac_pkg::FN_WR_C, 63, 0, 64'h8000_0000_0000_0000);
    send(mmac_pkg::FN_RD_C, 0, 0, 64'd0);
    send(mmac_pkg::FN_RD_C, 63, 63, 64'd0);
    send(mmac_pkg::FN_RD_C, 0, 63, 64'd0);
    send(mmac_pkg::FN_RD_C, 63, 0, 64'd0);
    send(mmac_pkg::FN_WR_A, 63, 63, 64'h0000_0000_0000_0001);
    send(mmac_pkg::FN_WR_B, 0, 0, 64'h7FEF_FFFF_FFFF_FFFF);
    send(3'd5, 63, 0, rnd64());
    send(3'd6, 0, 63, rnd64());
    send(3'd7, 63, 63, rnd64());
    set_size(127);
    send(mmac_pkg::FN_WR_C, 63, 63, 64'h0000_0000_0000_0001);
    send(mmac_pkg::FN_RD_C, 63, 63, 64'd0);
    set_size(0);
    send(mmac_pkg::FN_WR_A, 0, 0, rnd64());
    send(mmac_pkg::FN_RD_C, 0, 0, 64'd0);
    send(mmac_pkg::FN_RUN, 0, 0, 64'd0);
    set_size(1);
    send(mmac_pkg::FN_WR_A, 0, 0, 64'h3FF8_0000_0000_0000);
    send(mmac_pkg::FN_WR_B, 0, 0, 64'hC000_0000_0000_0000);
    send(mmac_pkg::FN_WR_C, 0, 0, 64'h7FEF_FFFF_FFFF_FFFF);
    send(mmac_pkg::FN_RUN, 0, 0, 64'd0);
    send(mmac_pkg::FN_RD_C, 0, 0, 64'd0);
    send(mmac_pkg::FN_WR_A, 0, 0, 64'h0010_0000_0000_0000);
    send(mmac_pkg::FN_WR_B, 0, 0, 64'h3FE0_0000_0000_0000);
    send(mmac_pkg::FN_WR_C, 0, 0, 64'h8000_0000_0000_0000);
    send(mmac_pkg::FN_RUN, 0, 0, 64'd0);
    send(mmac_pkg::FN_RD_C, 0, 0, 64'd0);

    for (int p = 0; p < 14; p++) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      sz = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : 6;
      set_size(sz);
      fill_all(sz);
      mix(30, 3);
    end
    no_gaps = 1'b0;
    set_size(8);
    fill_all(8);
    mix(40, 2);
    set_size(64);
    mix(120, 0);

    item_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fails == 0) begin
      $display("tb_matrix_multiply_accumulate passed");
    end else begin
      $display("tb_matrix_multiply_accumulate failed");
    end
    $finish;
  end

endmodule
